FILE: src/dcp_pkg.sv
package dcp_pkg;

	// Default coordinate format: signed Q16.16.
	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;

	// Fixed widths of the weight and rest length fields.
	localparam int WEIGHT_W = 32;
	localparam int REST_W   = 31;

	typedef enum logic [1:0] {
		OUT_APPLIED    = 2'd0,
		OUT_COINCIDENT = 2'd1,
		OUT_IMMOVABLE  = 2'd2,
		OUT_SATURATED  = 2'd3
	} outcome_t;

endpackage

FILE: src/dcp_delay.sv
module dcp_delay #(
	parameter int W = 8,
	parameter int D = 1
) (
	input  logic         clk,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	generate
		if (D == 0) begin : g_none
			assign q = d;
		end else begin : g_line
			logic [W-1:0] line_q [D];
			always_ff @(posedge clk) begin
				line_q[0] <= d;
				for (int k = 1; k < D; k++) begin
					line_q[k] <= line_q[k-1];
				end
			end
			assign q = line_q[D-1];
		end
	endgenerate

endmodule

FILE: src/dcp_mul.sv
module dcp_mul #(
	parameter int AW = 33,
	parameter int BW = 33
) (
	input  logic             clk,
	input  logic [AW-1:0]    a,
	input  logic [BW-1:0]    b,
	output logic [AW+BW-1:0] p_q
);

	// Operands are split in halves; the four partial products are registered
	// and summed in the second stage.
	localparam int AL = (AW + 1) / 2;
	localparam int AH = AW - AL;
	localparam int BL = (BW + 1) / 2;
	localparam int BH = BW - BL;
	localparam int PW = AW + BW;

	logic [AL+BL-1:0] ll_s1;
	logic [AL+BH-1:0] lh_s1;
	logic [AH+BL-1:0] hl_s1;
	logic [AH+BH-1:0] hh_s1;

	always_ff @(posedge clk) begin
		ll_s1 <= a[AL-1:0] * b[BL-1:0];
		lh_s1 <= a[AL-1:0] * b[BW-1:BL];
		hl_s1 <= a[AW-1:AL] * b[BL-1:0];
		hh_s1 <= a[AW-1:AL] * b[BW-1:BL];
	end

	always_ff @(posedge clk) begin
		p_q <= PW'(ll_s1) + (PW'(lh_s1) << BL) + (PW'(hl_s1) << AL)
			+ (PW'(hh_s1) << (AL + BL));
	end

endmodule

FILE: src/dcp_sqrt_cell.sv
module dcp_sqrt_cell #(
	parameter int LW = 34
) (
	input  logic            clk,
	input  logic [2*LW-1:0] rad,
	input  logic [LW+1:0]   rem,
	input  logic [LW-1:0]   root,
	output logic [2*LW-1:0] rad_q,
	output logic [LW+1:0]   rem_q,
	output logic [LW-1:0]   root_q
);

	// One result bit per cell: bring down two radicand bits and try 4*root+1.
	localparam int CUR_W = LW + 4;

	logic [CUR_W-1:0] cur;
	logic [CUR_W-1:0] trial;
	logic             ge;

	assign cur   = {rem, rad[2*LW-1 -: 2]};
	assign trial = CUR_W'({root, 2'b01});
	assign ge    = (cur >= trial);

	always_ff @(posedge clk) begin
		rad_q  <= {rad[2*LW-3:0], 2'b00};
		rem_q  <= ge ? (LW+2)'(cur - trial) : (LW+2)'(cur);
		root_q <= {root[LW-2:0], ge};
	end

endmodule

FILE: src/dcp_div_cell.sv
module dcp_div_cell #(
	parameter int DEN_W = 33,
	parameter int NUM_W = 17,
	parameter int Q_W   = 17
) (
	input  logic             clk,
	input  logic [DEN_W-1:0] den,
	input  logic [DEN_W-1:0] rem,
	input  logic [NUM_W-1:0] num,
	input  logic [Q_W-1:0]   quo,
	output logic [DEN_W-1:0] den_q,
	output logic [DEN_W-1:0] rem_q,
	output logic [NUM_W-1:0] num_q,
	output logic [Q_W-1:0]   quo_q
);

	// One restoring step per cell; the divisor travels with its operand.
	logic [DEN_W:0] trial;
	logic           ge;

	assign trial = {rem, num[NUM_W-1]};
	assign ge    = (trial >= {1'b0, den});

	always_ff @(posedge clk) begin
		den_q <= den;
		rem_q <= ge ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
		num_q <= {num[NUM_W-2:0], 1'b0};
		quo_q <= {quo[Q_W-2:0], ge};
	end

endmodule

FILE: src/distance_constraint_projector_top.sv
// Channel   Direction  Handshake          Word
// command   in         start / busy       a_*, b_*, weight_a, weight_b, rest_length
// result    out        done (one cycle)   new_a_*, new_b_*, outcome
//
// One word is taken every cycle; busy is never raised. Coordinates default to signed
// Q16.16. Words leave on done after the square root chain (COORD_WIDTH+2 cells)
// and the correction divider chain (one cell per quotient bit), with two-stage
// multipliers between. Reset only clears the valid pipeline; data registers hold
// whatever they last saw. The receiver cannot stall, so done flags each result
// for exactly one cycle.
module distance_constraint_projector_top #(
	parameter int COORD_WIDTH = dcp_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = dcp_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic signed [COORD_WIDTH-1:0]      a_x,
	input  logic signed [COORD_WIDTH-1:0]      a_y,
	input  logic signed [COORD_WIDTH-1:0]      a_z,
	input  logic signed [COORD_WIDTH-1:0]      b_x,
	input  logic signed [COORD_WIDTH-1:0]      b_y,
	input  logic signed [COORD_WIDTH-1:0]      b_z,
	input  logic [dcp_pkg::WEIGHT_W-1:0]       weight_a,
	input  logic [dcp_pkg::WEIGHT_W-1:0]       weight_b,
	input  logic [dcp_pkg::REST_W-1:0]         rest_length,
	output logic                               done,
	output logic signed [COORD_WIDTH-1:0]      new_a_x,
	output logic signed [COORD_WIDTH-1:0]      new_a_y,
	output logic signed [COORD_WIDTH-1:0]      new_a_z,
	output logic signed [COORD_WIDTH-1:0]      new_b_x,
	output logic signed [COORD_WIDTH-1:0]      new_b_y,
	output logic signed [COORD_WIDTH-1:0]      new_b_z,
	output dcp_pkg::outcome_t                  outcome
);

	import dcp_pkg::*;

	// Widths. The difference magnitude needs one bit over a coordinate, the length
	// one more, and |L - rest| is bounded by the wider of length and rest.
	localparam int CW   = COORD_WIDTH;
	localparam int F    = FRAC_BITS;
	localparam int DW   = CW + 1;
	localparam int LW   = CW + 2;
	localparam int RW   = 2 * LW;
	localparam int SW   = (CW + 1 > REST_W) ? CW + 1 : REST_W;
	localparam int QW   = SW;
	localparam int MW   = DW + SW;
	localparam int SHW  = F + 1;
	localparam int PW   = MW + SHW;
	localparam int DENW = LW + F;
	localparam int WSW  = WEIGHT_W + 1;
	localparam int EW   = QW + 2;

	// Stage numbers, counted from the edge that takes the word.
	localparam int T_L  = 4 + LW;
	localparam int T_M  = T_L + 3;
	localparam int T_SH = F + 2;
	localparam int T_P  = (T_M > T_SH) ? T_M : T_SH;
	localparam int T_Q  = T_P + 2 + QW;
	localparam int LAT  = T_Q + 1;

	localparam int SB1_W = 6 * CW + 3 * DW + 3 + REST_W + 1;
	localparam int SB2_W = 6 * CW + 5;

	localparam logic signed [EW-1:0] C_MAX = {{(EW-CW+1){1'b0}}, {(CW-1){1'b1}}};
	localparam logic signed [EW-1:0] C_MIN = {{(EW-CW+1){1'b1}}, {(CW-1){1'b0}}};

	logic            acc;
	logic [LAT:1]    valid_q;

	assign busy = 1'b0;
	assign acc  = start & ~busy;
	assign done = valid_q[LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= {valid_q[LAT-1:1], acc};
		end
	end

	// Stage 1: capture the word and form the differences and weight sum.
	logic [2:0][CW-1:0] ain, bin;
	logic [2:0][CW-1:0] a_s1, b_s1;
	logic [2:0][CW:0]   d_s1;
	logic [WSW-1:0]     wsum_s1;
	logic [REST_W-1:0]  rest_s1;

	assign ain = {a_z, a_y, a_x};
	assign bin = {b_z, b_y, b_x};

	always_ff @(posedge clk) begin
		a_s1    <= ain;
		b_s1    <= bin;
		for (int i = 0; i < 3; i++) begin
			d_s1[i] <= {bin[i][CW-1], bin[i]} - {ain[i][CW-1], ain[i]};
		end
		wsum_s1 <= {1'b0, weight_a} + {1'b0, weight_b};
		rest_s1 <= rest_length;
	end

	logic [2:0][DW-1:0] dmag_s1;
	logic [2:0]         dneg_s1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dneg_s1[i] = d_s1[i][CW];
			dmag_s1[i] = d_s1[i][CW] ? DW'(-d_s1[i]) : DW'(d_s1[i]);
		end
	end

	// Squared length.
	wire [2:0][2*DW-1:0] sqr;
	logic [RW-1:0]       sq_s4;

	genvar gi, gj, gk;
	generate
		for (gi = 0; gi < 3; gi++) begin : g_sq
			dcp_mul #(.AW(DW), .BW(DW)) u_sq (
				.clk (clk),
				.a   (dmag_s1[gi]),
				.b   (dmag_s1[gi]),
				.p_q (sqr[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk) begin
		sq_s4 <= RW'(sqr[0]) + RW'(sqr[1]) + RW'(sqr[2]);
	end

	// Square root: one cell per result bit.
	wire [LW:0][RW-1:0]   sr_rad;
	wire [LW:0][LW+1:0]   sr_rem;
	wire [LW:0][LW-1:0]   sr_root;

	assign sr_rad[0]  = sq_s4;
	assign sr_rem[0]  = '0;
	assign sr_root[0] = '0;

	generate
		for (gk = 0; gk < LW; gk++) begin : g_sqrt
			dcp_sqrt_cell #(.LW(LW)) u_cell (
				.clk    (clk),
				.rad    (sr_rad[gk]),
				.rem    (sr_rem[gk]),
				.root   (sr_root[gk]),
				.rad_q  (sr_rad[gk+1]),
				.rem_q  (sr_rem[gk+1]),
				.root_q (sr_root[gk+1])
			);
		end
	endgenerate

	// Mass shares: floor(w * 2^F / (wa + wb)), started right at stage 1.
	wire [1:0][SHW:0][WSW-1:0] sh_den, sh_rem;
	wire [1:0][SHW:0][SHW-1:0] sh_num, sh_q;
	logic [1:0][WEIGHT_W-1:0]  w_s1;

	always_ff @(posedge clk) begin
		w_s1[0] <= weight_a;
		w_s1[1] <= weight_b;
	end

	generate
		for (gj = 0; gj < 2; gj++) begin : g_sh
			assign sh_den[gj][0] = wsum_s1;
			assign sh_rem[gj][0] = WSW'(w_s1[gj] >> 1);
			assign sh_num[gj][0] = {w_s1[gj][0], {F{1'b0}}};
			assign sh_q[gj][0]   = '0;
			for (gk = 0; gk < SHW; gk++) begin : g_cell
				dcp_div_cell #(.DEN_W(WSW), .NUM_W(SHW), .Q_W(SHW)) u_cell (
					.clk   (clk),
					.den   (sh_den[gj][gk]),
					.rem   (sh_rem[gj][gk]),
					.num   (sh_num[gj][gk]),
					.quo   (sh_q[gj][gk]),
					.den_q (sh_den[gj][gk+1]),
					.rem_q (sh_rem[gj][gk+1]),
					.num_q (sh_num[gj][gk+1]),
					.quo_q (sh_q[gj][gk+1])
				);
			end
		end
	endgenerate

	// Side data from stage 1 to the square root output.
	logic [SB1_W-1:0] sb1_d;
	logic             wzero_s1;

	assign wzero_s1 = (wsum_s1 == '0);

	dcp_delay #(.W(SB1_W), .D(T_L - 1)) u_sb1 (
		.clk (clk),
		.d   ({wzero_s1, rest_s1, dneg_s1, dmag_s1, b_s1, a_s1}),
		.q   (sb1_d)
	);

	// Stage after the root: rest difference, divisor and the flags.
	logic [REST_W-1:0]   rest_l;
	logic [LW-1:0]       len_l;
	logic signed [SW:0]  s_l;
	logic [SB1_W-1:0]    sb_s5;
	logic [SW-1:0]       smag_s5;
	logic                sneg_s5;
	logic                lzero_s5;
	logic [DENW-1:0]     den_s5;

	assign len_l  = sr_root[LW];
	assign rest_l = sb1_d[3*CW*2+3*DW+3 +: REST_W];
	assign s_l    = $signed((SW+1)'(len_l)) - $signed((SW+1)'(rest_l));

	always_ff @(posedge clk) begin
		sb_s5    <= sb1_d;
		smag_s5  <= s_l[SW] ? SW'(-s_l) : SW'(s_l);
		sneg_s5  <= s_l[SW];
		lzero_s5 <= (len_l == '0);
		den_s5   <= {len_l, {F{1'b0}}};
	end

	logic [2:0][CW-1:0] a_s5, b_s5;
	logic [2:0][DW-1:0] dmag_s5;
	logic [2:0]         dneg_s5;
	logic               wzero_s5;

	// The rest length is no longer needed past this point.
	assign wzero_s5 = sb_s5[SB1_W-1];
	assign {dneg_s5, dmag_s5, b_s5, a_s5} = sb_s5[6*CW+3*DW+2:0];

	// |d| * |s| per axis, then times each share.
	wire [2:0][MW-1:0]  prod;
	logic [3*MW-1:0]    prod_d;
	logic [2*SHW-1:0]   share_d;
	wire [1:0][2:0][PW-1:0] num;

	generate
		for (gi = 0; gi < 3; gi++) begin : g_ds
			dcp_mul #(.AW(DW), .BW(SW)) u_ds (
				.clk (clk),
				.a   (dmag_s5[gi]),
				.b   (smag_s5),
				.p_q (prod[gi])
			);
		end
	endgenerate

	dcp_delay #(.W(3*MW), .D(T_P - T_M)) u_prod (
		.clk (clk),
		.d   (prod),
		.q   (prod_d)
	);

	dcp_delay #(.W(2*SHW), .D(T_P - T_SH)) u_share (
		.clk (clk),
		.d   ({sh_q[1][SHW], sh_q[0][SHW]}),
		.q   (share_d)
	);

	generate
		for (gj = 0; gj < 2; gj++) begin : g_nj
			for (gi = 0; gi < 3; gi++) begin : g_ni
				dcp_mul #(.AW(MW), .BW(SHW)) u_ns (
					.clk (clk),
					.a   (prod_d[gi*MW +: MW]),
					.b   (share_d[gj*SHW +: SHW]),
					.p_q (num[gj][gi])
				);
			end
		end
	endgenerate

	// Correction magnitudes: num / (L * 2^F), one quotient bit per cell.
	logic [DENW-1:0] den_d;

	dcp_delay #(.W(DENW), .D(T_P + 1 - T_L)) u_den (
		.clk (clk),
		.d   (den_s5),
		.q   (den_d)
	);

	wire [1:0][2:0][QW:0][DENW-1:0] cd_den, cd_rem;
	wire [1:0][2:0][QW:0][QW-1:0]   cd_num, cd_q;

	generate
		for (gj = 0; gj < 2; gj++) begin : g_cj
			for (gi = 0; gi < 3; gi++) begin : g_ci
				assign cd_den[gj][gi][0] = den_d;
				assign cd_rem[gj][gi][0] = num[gj][gi][PW-1:QW];
				assign cd_num[gj][gi][0] = num[gj][gi][QW-1:0];
				assign cd_q[gj][gi][0]   = '0;
				for (gk = 0; gk < QW; gk++) begin : g_cell
					dcp_div_cell #(.DEN_W(DENW), .NUM_W(QW), .Q_W(QW)) u_cell (
						.clk   (clk),
						.den   (cd_den[gj][gi][gk]),
						.rem   (cd_rem[gj][gi][gk]),
						.num   (cd_num[gj][gi][gk]),
						.quo   (cd_q[gj][gi][gk]),
						.den_q (cd_den[gj][gi][gk+1]),
						.rem_q (cd_rem[gj][gi][gk+1]),
						.num_q (cd_num[gj][gi][gk+1]),
						.quo_q (cd_q[gj][gi][gk+1])
					);
				end
			end
		end
	endgenerate

	// Side data from the post-root stage to the divider output.
	logic [SB2_W-1:0]   sb2_d;
	logic [2:0][CW-1:0] a_q, b_q;
	logic [2:0]         neg_q;
	logic               lzero_q, wzero_q;

	dcp_delay #(.W(SB2_W), .D(T_Q - T_L - 1)) u_sb2 (
		.clk (clk),
		.d   ({wzero_s5, lzero_s5, dneg_s5 ^ {3{sneg_s5}}, b_s5, a_s5}),
		.q   (sb2_d)
	);

	assign {wzero_q, lzero_q, neg_q, b_q, a_q} = sb2_d;

	// Apply the corrections with the sign of d*s and clamp to the coordinate range.
	function automatic logic [CW:0] clamp(input logic signed [EW-1:0] v);
		logic [CW:0] r;
		if (v > C_MAX) begin
			r = {1'b1, C_MAX[CW-1:0]};
		end else if (v < C_MIN) begin
			r = {1'b1, C_MIN[CW-1:0]};
		end else begin
			r = {1'b0, v[CW-1:0]};
		end
		return r;
	endfunction

	logic [2:0][CW-1:0] na_c, nb_c;
	outcome_t           outcome_c;

	always_comb begin
		logic signed [EW-1:0] qa, qb, va, vb;
		logic [CW:0]          ra, rb;
		logic                 sat;
		sat = 1'b0;
		for (int i = 0; i < 3; i++) begin
			qa = EW'($signed({1'b0, cd_q[0][i][QW]}));
			qb = EW'($signed({1'b0, cd_q[1][i][QW]}));
			va = EW'($signed(a_q[i])) + (neg_q[i] ? -qa : qa);
			vb = EW'($signed(b_q[i])) - (neg_q[i] ? -qb : qb);
			ra = clamp(va);
			rb = clamp(vb);
			sat = sat | ra[CW] | rb[CW];
			na_c[i] = ra[CW-1:0];
			nb_c[i] = rb[CW-1:0];
		end
		if (lzero_q) begin
			outcome_c = OUT_COINCIDENT;
			na_c      = a_q;
			nb_c      = b_q;
		end else if (wzero_q) begin
			outcome_c = OUT_IMMOVABLE;
			na_c      = a_q;
			nb_c      = b_q;
		end else if (sat) begin
			outcome_c = OUT_SATURATED;
		end else begin
			outcome_c = OUT_APPLIED;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_q[T_Q]) begin
			new_a_x <= na_c[0];
			new_a_y <= na_c[1];
			new_a_z <= na_c[2];
			new_b_x <= nb_c[0];
			new_b_y <= nb_c[1];
			new_b_z <= nb_c[2];
			outcome <= outcome_c;
		end
	end

	// Every word taken comes out after the fixed latency.
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("result strobe missing after fixed latency");

	// Coincident points leave both particles at the same place.
	assert property (@(posedge clk) disable iff (!arst_n)
		done && outcome == OUT_COINCIDENT |->
			new_a_x == new_b_x && new_a_y == new_b_y && new_a_z == new_b_z)
		else $error("coincident result moved the points apart");

	// Immovable pairs pass the x and y of A through unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		done && outcome == OUT_IMMOVABLE |->
			new_a_x == $past(a_x, LAT) && new_a_y == $past(a_y, LAT))
		else $error("immovable pair was moved");

endmodule
